// File: rtl/ttl_hash_table_unit_macros.svh
// ----------------------------------------------------------------------------
// ttl_hash_table_unit assertion macros
// Shared concurrent assertion forms for the hash table unit.
// ----------------------------------------------------------------------------
`ifndef TTL_HASH_TABLE_UNIT_MACROS_SVH
`define TTL_HASH_TABLE_UNIT_MACROS_SVH

// implication checked every cycle outside reset
`define TTL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define TTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/tht_pkg.sv
// ----------------------------------------------------------------------------
// tht_pkg
// Types, constants and helpers for the TTL hash table unit.
// ----------------------------------------------------------------------------
package tht_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int KEY_BYTES_DEF     = 8;
   localparam int PERTURB_SHIFT     = 5;

   localparam logic [1:0] OP_ADD        = 2'd0;
   localparam logic [1:0] OP_GET        = 2'd1;
   localparam logic [1:0] OP_INVALIDATE = 2'd2;

   localparam logic [2:0] ST_NEW          = 3'd0;
   localparam logic [2:0] ST_OVERWRITTEN  = 3'd1;
   localparam logic [2:0] ST_EXP_REPLACED = 3'd2;
   localparam logic [2:0] ST_FOUND        = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND    = 3'd4;
   localparam logic [2:0] ST_EXP_ERASED   = 3'd5;
   localparam logic [2:0] ST_INVALIDATED  = 3'd6;
   localparam logic [2:0] ST_FULL         = 3'd7;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] key;
      logic [31:0] expiry;
      logic [31:0] payload;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_expiry;
      logic [31:0] out_payload;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic [1:0]  op;
      logic        nop;
      logic [63:0] nkey;
      logic [63:0] hash;
      logic [31:0] expiry;
      logic [31:0] payload;
      logic [31:0] now;
   } cmd_type;

   function automatic logic [63:0] djb2_step(input logic [63:0] h, input logic [7:0] b);
      djb2_step = (h << 5) + h + {56'd0, b};
   endfunction

endpackage

// File: rtl/tht_ram.sv
// ----------------------------------------------------------------------------
// tht_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: rtl/tht_front.sv
// ----------------------------------------------------------------------------
// tht_front
// Accepts transactions, normalizes the key and hashes it one byte per cycle.
// ----------------------------------------------------------------------------
module tht_front #(
   parameter int KEY_BYTES = tht_pkg::KEY_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  tht_pkg::req_type req,
   output logic             busy_front,
   output logic             cmd_valid,
   output tht_pkg::cmd_type cmd,
   input  logic             cmd_ready
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_HASH = 2'd1;
   localparam logic [1:0] S_HOLD = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [2:0]       byte_ff, byte_in;
   logic             done_ff, done_in;
   tht_pkg::cmd_type cmd_ff, cmd_in;
   logic [7:0]       cur_byte;

   assign cur_byte   = cmd_ff.nkey[8*byte_ff +: 8];
   assign busy_front = (state_ff != S_IDLE);
   assign cmd_valid  = (state_ff == S_HOLD);
   assign cmd        = cmd_ff;

   always_comb begin
      state_in = state_ff;
      byte_in  = byte_ff;
      done_in  = done_ff;
      cmd_in   = cmd_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in.op      = req.op;
               cmd_in.nkey    = req.key;
               cmd_in.expiry  = req.expiry;
               cmd_in.payload = req.payload;
               cmd_in.now     = req.now;
               cmd_in.hash    = 64'd5381;
               cmd_in.nop     = 1'b0;
               byte_in        = 3'd0;
               done_in        = 1'b0;
               state_in       = S_HASH;
            end
         end
         S_HASH: begin
            if (done_ff || (32'(byte_ff) >= 32'(KEY_BYTES)) || cur_byte == 8'd0) begin
               cmd_in.nkey[8*byte_ff +: 8] = 8'd0;
               done_in = 1'b1;
            end else begin
               cmd_in.hash = tht_pkg::djb2_step(cmd_ff.hash, cur_byte);
            end
            byte_in = byte_ff + 3'd1;
            if (byte_ff == 3'd7) begin
               cmd_in.nop = (cmd_in.nkey == 64'd0) ||
                  !(cmd_ff.op == tht_pkg::OP_ADD || cmd_ff.op == tht_pkg::OP_GET ||
                    cmd_ff.op == tht_pkg::OP_INVALIDATE);
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (cmd_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      byte_ff <= byte_in;
      done_ff <= done_in;
      cmd_ff  <= cmd_in;
   end
endmodule

// File: rtl/tht_back.sv
// ----------------------------------------------------------------------------
// tht_back
// Clears the table, purges on high occupancy, walks the probe sequence and
// writes results.
// ----------------------------------------------------------------------------
module tht_back #(
   parameter int TABLE_ENTRIES = tht_pkg::TABLE_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  tht_pkg::cmd_type cmd,
   output logic             cmd_ready,
   output logic             busy_back,
   output logic             rsp_strobe,
   output tht_pkg::rsp_type rsp
);
   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = AW + 1;
   localparam int SW = 2 * AW + 1;
   localparam logic [SW-1:0] SUM_LIMIT =
      SW'((TABLE_ENTRIES * (TABLE_ENTRIES + 1)) / 2);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_PREAD = 4'd2;
   localparam logic [3:0] S_PCHK  = 4'd3;
   localparam logic [3:0] S_READ  = 4'd4;
   localparam logic [3:0] S_CHK   = 4'd5;
   localparam logic [3:0] S_DONE  = 4'd6;

   logic [3:0]       state_ff, state_in;
   tht_pkg::cmd_type c_ff, c_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [63:0]      pert_ff, pert_in;
   logic [SW-1:0]    sum_ff, sum_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    live_ff, live_in;
   tht_pkg::rsp_type rsp_ff, rsp_in;
   logic             strobe_ff, strobe_in;

   logic             k_we, d_we;
   logic [AW-1:0]    wa, ra;
   logic [63:0]      k_wd, k_rd;
   logic [31:0]      e_rd, p_rd, e_wd, p_wd;
   logic [SW-1:0]    sum_nx;
   logic [63:0]      pert_nx;
   logic [AW-1:0]    idx_nx;

   tht_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_key (
      .clock, .wr_en(k_we), .wr_addr(wa), .wr_data(k_wd), .rd_addr(ra), .rd_data(k_rd));
   tht_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_exp (
      .clock, .wr_en(d_we), .wr_addr(wa), .wr_data(e_wd), .rd_addr(ra), .rd_data(e_rd));
   tht_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_pay (
      .clock, .wr_en(d_we), .wr_addr(wa), .wr_data(p_wd), .rd_addr(ra), .rd_data(p_rd));

   assign cmd_ready  = (state_ff == S_IDLE);
   assign busy_back  = (state_ff != S_IDLE) || strobe_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;
   assign sum_nx     = sum_ff + SW'(idx_ff);
   assign pert_nx    = pert_ff >> tht_pkg::PERTURB_SHIFT;
   assign idx_nx     = AW'(idx_ff * AW'(5)) + AW'(pert_nx) + AW'(1);

   always_comb begin
      state_in  = state_ff;
      c_in      = c_ff;
      idx_in    = idx_ff;
      pert_in   = pert_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      live_in   = live_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      k_we = 1'b0; d_we = 1'b0;
      wa = idx_ff; ra = idx_ff;
      k_wd = 64'd0; e_wd = 32'd0; p_wd = 32'd0;
      case (state_ff)
         S_CLEAR: begin
            k_we = 1'b1; d_we = 1'b1;
            idx_in = idx_ff + AW'(1);
            if (idx_ff == AW'(TABLE_ENTRIES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (cmd_valid) begin
               c_in    = cmd;
               idx_in  = AW'(cmd.hash);
               pert_in = cmd.hash;
               sum_in  = '0;
               rsp_in  = '{tht_pkg::ST_NOT_FOUND, 32'd0, 32'd0};
               if (cmd.nop) begin
                  state_in = S_DONE;
               end else if (cmd.op == tht_pkg::OP_ADD &&
                            (32'(count_ff) * 3 > 32'(TABLE_ENTRIES) * 2)) begin
                  live_in  = '0;
                  state_in = S_PREAD;
                  idx_in   = '0;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_PREAD: state_in = S_PCHK;
         S_PCHK: begin
            if (k_rd != 64'd0 && e_rd > c_ff.now) begin
               live_in = live_ff + CW'(1);
            end else begin
               k_we = 1'b1;
            end
            k_wd = k_rd & {64{~k_we}};
            idx_in = idx_ff + AW'(1);
            ra = idx_in;
            state_in = S_PREAD;
            if (idx_ff == AW'(TABLE_ENTRIES - 1)) begin
               count_in = live_in;
               idx_in   = AW'(c_ff.hash);
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_CHK;
         S_CHK: begin
            state_in = S_DONE;
            if (c_ff.op == tht_pkg::OP_ADD) begin
               if (k_rd == 64'd0 || k_rd == c_ff.nkey || e_rd < c_ff.now) begin
                  k_we = 1'b1; d_we = 1'b1;
                  k_wd = c_ff.nkey; e_wd = c_ff.expiry; p_wd = c_ff.payload;
                  if (k_rd == 64'd0) begin
                     rsp_in.status = tht_pkg::ST_NEW;
                     count_in = count_ff + CW'(1);
                  end else if (k_rd == c_ff.nkey) begin
                     rsp_in.status = tht_pkg::ST_OVERWRITTEN;
                  end else begin
                     rsp_in.status = tht_pkg::ST_EXP_REPLACED;
                  end
               end else if (sum_nx >= SUM_LIMIT) begin
                  rsp_in.status = tht_pkg::ST_FULL;
               end else begin
                  state_in = S_READ;
               end
            end else begin
               if (k_rd == c_ff.nkey) begin
                  if (c_ff.now <= e_rd) begin
                     rsp_in.out_expiry  = e_rd;
                     rsp_in.out_payload = p_rd;
                     if (c_ff.op == tht_pkg::OP_GET) begin
                        rsp_in.status = tht_pkg::ST_FOUND;
                     end else begin
                        rsp_in.status = tht_pkg::ST_INVALIDATED;
                        k_we = 1'b1;
                        if (count_ff != '0) count_in = count_ff - CW'(1);
                     end
                  end else begin
                     k_we = 1'b1;
                     rsp_in.status = (c_ff.op == tht_pkg::OP_GET) ?
                        tht_pkg::ST_EXP_ERASED : tht_pkg::ST_NOT_FOUND;
                  end
               end else if (sum_nx < SUM_LIMIT) begin
                  state_in = S_READ;
               end
            end
            if (state_in == S_READ) begin
               sum_in  = sum_nx;
               pert_in = pert_nx;
               idx_in  = idx_nx;
            end
         end
         S_DONE: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff != S_PCHK) ra = idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         idx_ff    <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      c_ff    <= c_in;
      pert_ff <= pert_in;
      sum_ff  <= sum_in;
      live_ff <= live_in;
      rsp_ff  <= rsp_in;
   end
endmodule

// File: rtl/ttl_hash_table_unit.sv
// An ignored transaction skips the probe walk; each extra probe lengthens a
// transaction, and an add at more than 2/3 occupancy first sweeps all slots.
// Transactions are taken one at a time. Reset clears every slot in one pass;
// busy is high then. The receiver cannot stall: rsp_strobe lasts one cycle.
// ----------------------------------------------------------------------------
// ttl_hash_table_unit
// Open-addressed key, expiry and payload table with TTL expiry.
// ----------------------------------------------------------------------------
`include "ttl_hash_table_unit_macros.svh"
module ttl_hash_table_unit #(
   parameter int TABLE_ENTRIES = tht_pkg::TABLE_ENTRIES_DEF,
   parameter int KEY_BYTES     = tht_pkg::KEY_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  tht_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_strobe,
   output tht_pkg::rsp_type rsp_data
);
   logic             busy_front, busy_back, cmd_valid, cmd_ready;
   tht_pkg::cmd_type cmd;

   tht_front #(.KEY_BYTES(KEY_BYTES)) u_front (
      .clock, .reset, .start(start && !busy), .req(req_data), .busy_front,
      .cmd_valid, .cmd, .cmd_ready);

   tht_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_ready, .busy_back,
      .rsp_strobe, .rsp(rsp_data));

   assign busy = busy_front || busy_back;

   `TTL_ASSERT_IMPL(a_strobe_busy, clock, reset, rsp_strobe, busy)
   `TTL_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `TTL_ASSERT_IMPL(a_handoff, clock, reset, cmd_valid && cmd_ready, busy_front)
endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ttl_hash_table_unit: add, get, invalidate and
// unused-op transactions, mostly on a small key set, predicted by a behavioral
// table model and checked against every response strobe.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N = tht_pkg::TABLE_ENTRIES_DEF;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   class table_scoreboard;
      logic [63:0] keys[N];
      logic [31:0] exps[N];
      logic [31:0] pays[N];
      int unsigned used;
      tht_pkg::rsp_type pending[$];
      int errors;

      function new();
         for (int i = 0; i < N; i++) begin
            keys[i] = '0; exps[i] = '0; pays[i] = '0;
         end
         used = 0; errors = 0;
      endfunction

      function logic [63:0] norm(logic [63:0] k);
         logic [63:0] r;
         r = '0;
         for (int i = 0; i < tht_pkg::KEY_BYTES_DEF; i++) begin
            if (k[8*i +: 8] == 8'd0) break;
            r[8*i +: 8] = k[8*i +: 8];
         end
         return r;
      endfunction

      function logic [63:0] hash_of(logic [63:0] nk);
         logic [63:0] h;
         h = 64'd5381;
         for (int i = 0; i < 8; i++) begin
            if (nk[8*i +: 8] == 8'd0) break;
            h = (h << 5) + h + {56'd0, nk[8*i +: 8]};
         end
         return h;
      endfunction

      // walk probe sequence; for_add selects the add slot test
      function int locate(logic [63:0] nk, logic [31:0] now, bit for_add,
                          output logic [2:0] st);
         logic [63:0] h, idx, pert, sum;
         h = hash_of(nk); idx = h & (N - 1); pert = h; sum = 0;
         st = tht_pkg::ST_NOT_FOUND;
         for (int s = 0; s < 4 * N + 64; s++) begin
            if (for_add) begin
               if (keys[idx] == 0) begin st = tht_pkg::ST_NEW; return int'(idx); end
               if (keys[idx] == nk) begin
                  st = tht_pkg::ST_OVERWRITTEN; return int'(idx);
               end
               if (exps[idx] < now) begin
                  st = tht_pkg::ST_EXP_REPLACED; return int'(idx);
               end
            end else if (keys[idx] == nk) return int'(idx);
            sum += idx;
            if (sum >= N * (N + 1) / 2) break;
            pert >>= tht_pkg::PERTURB_SHIFT;
            idx = (idx * 5 + pert + 1) & (N - 1);
         end
         return -1;
      endfunction

      function void note(tht_pkg::req_type r);
         tht_pkg::rsp_type e;
         logic [63:0] nk;
         int s;
         logic [2:0] st;
         nk = norm(r.key);
         e = '0; e.status = tht_pkg::ST_NOT_FOUND;
         if (nk != 0 && r.op == tht_pkg::OP_ADD) begin
            if (used * 3 > N * 2) begin
               used = 0;
               for (int i = 0; i < N; i++)
                  if (keys[i] != 0 && exps[i] > r.now) used++;
                  else keys[i] = '0;
            end
            s = locate(nk, r.now, 1, st);
            if (s < 0) e.status = tht_pkg::ST_FULL;
            else begin
               e.status = st;
               if (st == tht_pkg::ST_NEW) used++;
               keys[s] = nk; exps[s] = r.expiry; pays[s] = r.payload;
            end
         end else if (nk != 0 && (r.op == tht_pkg::OP_GET ||
                                  r.op == tht_pkg::OP_INVALIDATE)) begin
            s = locate(nk, r.now, 0, st);
            if (s >= 0) begin
               if (r.now <= exps[s]) begin
                  e.out_expiry = exps[s]; e.out_payload = pays[s];
                  if (r.op == tht_pkg::OP_GET) e.status = tht_pkg::ST_FOUND;
                  else begin
                     e.status = tht_pkg::ST_INVALIDATED; keys[s] = '0;
                     if (used > 0) used--;
                  end
               end else begin
                  keys[s] = '0;
                  e.status = (r.op == tht_pkg::OP_GET) ?
                     tht_pkg::ST_EXP_ERASED : tht_pkg::ST_NOT_FOUND;
               end
            end
         end
         pending.push_back(e);
      endfunction

      function void check(tht_pkg::rsp_type a);
         tht_pkg::rsp_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", a);
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status || a.out_expiry !== e.out_expiry ||
             a.out_payload !== e.out_payload) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp st=%0d ex=%h pl=%h, got st=%0d ex=%h pl=%h",
                        e.status, e.out_expiry, e.out_payload,
                        a.status, a.out_expiry, a.out_payload);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0;
   tht_pkg::req_type req_data = '0;
   logic busy, rsp_strobe;
   tht_pkg::rsp_type rsp_data;
   table_scoreboard sb = new();
   bit calm = 0;
   logic [63:0] key_pool[24];

   ttl_hash_table_unit dut (.*);

   always begin #5 clock = 1; #5 clock = 0; end

   always @(posedge clock)
      if (!reset && rsp_strobe) sb.check(rsp_data);

   task automatic send(logic [1:0] op, logic [63:0] key, logic [31:0] ex,
                       logic [31:0] pl, logic [31:0] now);
      tht_pkg::req_type r;
      r.op = op; r.key = key; r.expiry = ex; r.payload = pl; r.now = now;
      if (!calm && $urandom_range(3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start <= 1; req_data <= r;
      do @(posedge clock); while (busy);
      sb.note(r);
      start <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      logic [31:0] t;
      logic [1:0] op;
      logic [63:0] k;
      for (int i = 0; i < 24; i++)
         key_pool[i] = {$urandom, $urandom} | 64'h1;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send(tht_pkg::OP_ADD, 64'h41, 32'd100, 32'hFFFF_FFFF, 32'd10);
      send(tht_pkg::OP_GET, 64'h41, 0, 0, 32'd100);
      send(tht_pkg::OP_ADD, 64'h41, 32'hFFFF_FFFF, 32'h1234, 32'd0);
      send(tht_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'd5, 32'd7, 32'd0);
      send(tht_pkg::OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 32'd6);
      send(tht_pkg::OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 32'd6);
      send(tht_pkg::OP_ADD, 64'h00FF_0042, 32'd50, 32'd1, 32'd0);
      send(tht_pkg::OP_INVALIDATE, 64'h42, 0, 0, 32'd60);
      send(tht_pkg::OP_ADD, 64'h42, 32'd50, 32'd2, 32'd0);
      send(tht_pkg::OP_INVALIDATE, 64'h1122_0042, 0, 0, 32'd50);
      send(tht_pkg::OP_INVALIDATE, 64'h42, 0, 0, 32'd0);
      send(tht_pkg::OP_ADD, 64'hFF00, 32'd1, 32'd1, 32'd0);
      send(tht_pkg::OP_GET, 64'h0, 0, 0, 32'd0);
      send(tht_pkg::OP_INVALIDATE, 64'h0, 0, 0, 32'd0);
      send(OP_UNUSED, 64'h41, 0, 0, 32'd0);
      send(tht_pkg::OP_INVALIDATE, 64'h77, 0, 0, 32'hFFFF_FFFF);
      drain();
      // fill past two thirds with long-lived entries, then force full/expiry
      for (int i = 0; i < 70; i++)
         send(tht_pkg::OP_ADD, {$urandom, $urandom} | 64'h1, 32'hFFFF_FFF0, $urandom,
              32'd0);
      send(tht_pkg::OP_ADD, 64'h99, 32'd1, 32'd1, 32'hFFFF_FFFF);
      drain();
      // random traffic, mostly over a small key pool, with a moving clock
      t = 0;
      for (int i = 0; i < 1000; i++) begin
         if (i == 850) calm = 1;
         t += $urandom_range(0, 6);
         op = ($urandom_range(9) == 0) ? OP_UNUSED : 2'($urandom_range(2));
         case ($urandom_range(9))
            0: k = {$urandom, $urandom};
            1: k = '0;
            default: k = key_pool[$urandom_range(23)];
         endcase
         if ($urandom_range(15) == 0) t = $urandom;
         send(op, k, t + $urandom_range(0, 40), $urandom, t);
      end
      drain();
      if (sb.errors == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb failed");
      $finish;
   end
endmodule
